### rtl/core/bsc_pkg.sv
package bsc_pkg;

	// Calibration and mode registers as seen by the datapath
	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [1:0]  oss;
	} coef_t;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_AC1     = 3'd0;
	localparam logic [2:0] REG_AC2     = 3'd1;
	localparam logic [2:0] REG_AC3     = 3'd2;
	localparam logic [2:0] REG_AC4     = 3'd3;
	localparam logic [2:0] REG_AC5_AC6 = 3'd4;
	localparam logic [2:0] REG_B1_B2   = 3'd5;
	localparam logic [2:0] REG_MC_MD   = 3'd6;
	localparam logic [2:0] REG_OSS     = 3'd7;

	// Serial arithmetic unit operations
	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
	} au_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} au_rsp_t;

	localparam int  AU_BITS = 32;

	// Compensation steps, one unit operation each
	localparam logic [3:0] STEP_X1    = 4'd0;
	localparam logic [3:0] STEP_X2    = 4'd1;
	localparam logic [3:0] STEP_SQ    = 4'd2;
	localparam logic [3:0] STEP_B2SQ  = 4'd3;
	localparam logic [3:0] STEP_AC2   = 4'd4;
	localparam logic [3:0] STEP_AC3   = 4'd5;
	localparam logic [3:0] STEP_B1SQ  = 4'd6;
	localparam logic [3:0] STEP_B4    = 4'd7;
	localparam logic [3:0] STEP_B7    = 4'd8;
	localparam logic [3:0] STEP_P     = 4'd9;
	localparam logic [3:0] STEP_PP    = 4'd10;
	localparam logic [3:0] STEP_PP3K  = 4'd11;
	localparam logic [3:0] STEP_P7K   = 4'd12;

	localparam logic [31:0] K_B6_OFS  = 32'd4000;
	localparam logic [31:0] K_X3_OFS  = 32'd32768;
	localparam logic [31:0] K_B7_SCL  = 32'd50000;
	localparam logic [31:0] K_PP_MUL  = 32'd3038;
	localparam logic [31:0] K_P_MUL   = 32'hFFFF_E343;  // -7357
	localparam logic [31:0] K_P_OFS   = 32'd3791;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

### rtl/core/bsc_muldiv.sv
// Shared bit-serial unit: shift-add multiply (mod 2^32) or restoring
// unsigned divide, one bit per cycle
module bsc_muldiv import bsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  au_req_t req,
	output au_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	op_t         op_q;
	logic [31:0] a_q;     // multiplicand, or dividend/quotient
	logic [31:0] b_q;     // multiplier, or divisor
	logic [31:0] acc_q;   // product, or remainder
	logic [32:0] shifted;
	logic [32:0] diff;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(AU_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Divide trial subtract
	always_comb begin
		shifted = {acc_q, a_q[31]};
		diff    = shifted - {1'b0, b_q};
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q <= {a_q[30:0], 1'b0};
				b_q <= {1'b0, b_q[31:1]};
			end else begin
				acc_q <= diff[32] ? shifted[31:0] : diff[31:0];
				a_q   <= {a_q[30:0], ~diff[32]};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_DIV) ? a_q : acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("unit started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	a_done_time: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 5'd31 && !req.start) |=> done_q)
		else $error("done missing after last bit");

endmodule

### rtl/core/bsc_seq.sv
// Step sequencer: issues each multiply and divide of the compensation to
// the serial unit and folds the result into the working registers
module bsc_seq import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  coef_t       cfg,
	input  logic [15:0] raw_temp,
	input  logic [18:0] raw_pres,
	input  logic        ack,
	output logic        idle,
	output logic        res_valid,
	output logic [31:0] res_temp,
	output logic [31:0] res_pres,
	output logic        res_err,
	output au_req_t     req,
	input  au_rsp_t     rsp
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [3:0]  step_q;
	logic        neg_q;
	logic [31:0] x1_q, b6_q, sq_q, t1_q, x3_q, b3_q, b4_q, b7_q, p_q, dv_q;
	logic [31:0] temp_q, pres_q;
	logic        err_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, mcs;
	logic [31:0] r, x1_0, dv_0, qs, b5, x3_4, tmp4, v4, b3_4, x3_6, pres12, pa;
	logic [31:0] op_a, op_b;
	op_t         op;

	// Coefficient unpacking
	always_comb begin
		ac1 = sx16(cfg.ac1);
		ac2 = sx16(cfg.ac2);
		ac3 = sx16(cfg.ac3);
		ac4 = {16'd0, cfg.ac4};
		ac5 = {16'd0, cfg.ac5_ac6[31:16]};
		ac6 = {16'd0, cfg.ac5_ac6[15:0]};
		b1  = sx16(cfg.b1_b2[31:16]);
		b2  = sx16(cfg.b1_b2[15:0]);
		mc  = sx16(cfg.mc_md[31:16]);
		md  = sx16(cfg.mc_md[15:0]);
		mcs = {mc[20:0], 11'd0};
	end

	// Post-processing of each unit result
	always_comb begin
		r      = rsp.result;
		x1_0   = asr(r, 5'd15);
		dv_0   = x1_0 + md;
		qs     = neg_q ? (32'd0 - r) : r;
		b5     = x1_q + qs;
		x3_4   = t1_q + asr(r, 5'd11);
		tmp4   = ({ac1[29:0], 2'b00} + x3_4) << cfg.oss;
		v4     = tmp4 + 32'd2;
		b3_4   = v4[31] ? asr(v4 + 32'd3, 5'd2) : {2'b00, v4[31:2]};
		x3_6   = asr(t1_q + asr(r, 5'd16) + 32'd2, 5'd2);
		pres12 = p_q + asr(t1_q + asr(r, 5'd16) + K_P_OFS, 5'd4);
		pa     = asr(p_q, 5'd8);
	end

	// Operand selection per step
	always_comb begin
		op   = OP_MUL;
		op_a = '0;
		op_b = '0;
		case (step_q)
			STEP_X1: begin
				op_a = {16'd0, raw_temp} - ac6;
				op_b = ac5;
			end
			STEP_X2: begin
				op   = OP_DIV;
				op_a = mcs[31] ? (32'd0 - mcs) : mcs;
				op_b = dv_q[31] ? (32'd0 - dv_q) : dv_q;
			end
			STEP_SQ:   begin op_a = b6_q; op_b = b6_q; end
			STEP_B2SQ: begin op_a = b2;   op_b = sq_q; end
			STEP_AC2:  begin op_a = ac2;  op_b = b6_q; end
			STEP_AC3:  begin op_a = ac3;  op_b = b6_q; end
			STEP_B1SQ: begin op_a = b1;   op_b = sq_q; end
			STEP_B4:   begin op_a = ac4;  op_b = x3_q + K_X3_OFS; end
			STEP_B7: begin
				op_a = {13'd0, raw_pres} - b3_q;
				op_b = K_B7_SCL >> cfg.oss;
			end
			STEP_P: begin
				op   = OP_DIV;
				op_a = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
				op_b = b4_q;
			end
			STEP_PP:   begin op_a = pa;       op_b = pa; end
			STEP_PP3K: begin op_a = t1_q;     op_b = K_PP_MUL; end
			STEP_P7K:  begin op_a = K_P_MUL;  op_b = p_q; end
			default: ;
		endcase
	end

	assign req.start = (state_q == ST_ISSUE);
	assign req.op    = op;
	assign req.a     = op_a;
	assign req.b     = op_b;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_X1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_ISSUE;
						step_q  <= STEP_X1;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (rsp.done) begin
						if ((step_q == STEP_X1 && dv_0 == 32'd0) ||
							(step_q == STEP_B4 && r[31:15] == 17'd0) ||
							step_q == STEP_P7K) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ISSUE;
							step_q  <= step_q + 4'd1;
						end
					end
				end
				ST_DONE: if (ack) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go) begin
			err_q  <= 1'b0;
			temp_q <= '0;
			pres_q <= '0;
		end else if (state_q == ST_WAIT && rsp.done) begin
			case (step_q)
				STEP_X1: begin
					x1_q  <= x1_0;
					dv_q  <= dv_0;
					neg_q <= mcs[31] ^ dv_0[31];
					if (dv_0 == 32'd0) err_q <= 1'b1;
				end
				STEP_X2: begin
					temp_q <= asr(b5 + 32'd8, 5'd4);
					b6_q   <= b5 - K_B6_OFS;
				end
				STEP_SQ:   sq_q <= asr(r, 5'd12);
				STEP_B2SQ: t1_q <= asr(r, 5'd11);
				STEP_AC2:  b3_q <= b3_4;
				STEP_AC3:  t1_q <= asr(r, 5'd13);
				STEP_B1SQ: x3_q <= x3_6;
				STEP_B4: begin
					b4_q <= {15'd0, r[31:15]};
					if (r[31:15] == 17'd0) begin
						err_q  <= 1'b1;
						temp_q <= '0;
					end
				end
				STEP_B7:   b7_q <= r;
				STEP_P:    p_q  <= b7_q[31] ? {r[30:0], 1'b0} : r;
				STEP_PP:   t1_q <= r;
				STEP_PP3K: t1_q <= asr(r, 5'd16);
				STEP_P7K:  pres_q <= pres12;
				default: ;
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_temp  = err_q ? 32'd0 : temp_q;
	assign res_pres  = err_q ? 32'd0 : pres_q;
	assign res_err   = err_q;

	a_issue_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |=> (state_q == ST_WAIT)) else $error("issue not followed by wait");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !ack) |=> (state_q == ST_DONE))
		else $error("result dropped before taken");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_P7K) else $error("step out of range");

endmodule

### rtl/core/barometric_sensor_compensation.sv
// Barometric compensation. Each input transfer (tuser 0: raw temperature in
// tdata[15:0], tuser 1: raw pressure bytes) updates the stored raw value and
// starts one compensation pass, which yields one output transfer with the
// temperature in 0.1 degC, the pressure in Pa and a divide error flag. All
// multiplies and divides run through one shared bit-serial unit at one
// bit per cycle: 11 multiplies and 2 divides per pass, each issued and awaited
// by the sequencer, and a zero divisor ends the pass early. A finished result
// sits in the output register while the next item is computed. The user must
// write coefficients only while idle; the block itself does not enforce this.
module barometric_sensor_compensation import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // raw_reading[23:0]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // temperature_tenths[31:0], pressure_pa[63:32]
	output logic        m_tuser,   // divide_error
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	coef_t       cfg_q;
	logic [15:0] raw_temp_q;
	logic [18:0] raw_pres_q;
	logic        go;
	logic        idle, res_valid, res_err, ack;
	logic [31:0] res_temp, res_pres;
	au_req_t     req;
	au_rsp_t     rsp;
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;
	logic [23:0] pres_shift;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1:     cfg_q.ac1     <= cfg_wdata[15:0];
				REG_AC2:     cfg_q.ac2     <= cfg_wdata[15:0];
				REG_AC3:     cfg_q.ac3     <= cfg_wdata[15:0];
				REG_AC4:     cfg_q.ac4     <= cfg_wdata[15:0];
				REG_AC5_AC6: cfg_q.ac5_ac6 <= cfg_wdata;
				REG_B1_B2:   cfg_q.b1_b2   <= cfg_wdata;
				REG_MC_MD:   cfg_q.mc_md   <= cfg_wdata;
				REG_OSS:     cfg_q.oss     <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Input transfer and raw value store
	assign s_tready   = idle;
	assign go         = s_tvalid && s_tready;
	assign pres_shift = s_tdata >> (4'd8 - {2'b00, cfg_q.oss});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_temp_q <= '0;
			raw_pres_q <= '0;
		end else if (go) begin
			if (s_tuser) raw_pres_q <= pres_shift[18:0];
			else         raw_temp_q <= s_tdata[15:0];
		end
	end

	bsc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cfg       (cfg_q),
		.raw_temp  (raw_temp_q),
		.raw_pres  (raw_pres_q),
		.ack       (ack),
		.idle      (idle),
		.res_valid (res_valid),
		.res_temp  (res_temp),
		.res_pres  (res_pres),
		.res_err   (res_err),
		.req       (req),
		.rsp       (rsp)
	);

	bsc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Output register
	assign ack = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			m_tdata_q <= {res_pres, res_temp};
			m_tuser_q <= res_err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### test/tb_barometric_sensor_compensation.sv
`timescale 1ns / 100ps

module tb_barometric_sensor_compensation;
	import bsc_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [23:0] raw;
	} reading_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] pres;
		logic        div_err;
	} comp_t;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // raw_reading[23:0]
	logic        s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // temperature_tenths[31:0], pressure_pa[63:32]
	logic        m_tuser;   // divide_error
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	reading_t    pending_readings[$];
	comp_t       expected_comps[$];
	int          fail_count;
	int          idle_cycles;
	int          wait_gap;
	bit          hold_sender;
	bit          in_accepted;

	// shadow of the block's registers and stored readings
	logic [15:0] m_ac1, m_ac2, m_ac3, m_ac4;
	logic [31:0] m_ac56, m_b12, m_mcmd;
	logic [1:0]  m_oss;
	logic [15:0] m_raw_t;
	logic [18:0] m_raw_p;

	barometric_sensor_compensation u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sar(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// signed divide truncating toward zero
	function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] d);
		logic [31:0] ma, md, q;
		ma = a[31] ? -a : a;
		md = d[31] ? -d : d;
		q = ma / md;
		return (a[31] != d[31]) ? -q : q;
	endfunction

	// update stored readings and compute the compensated values
	function automatic comp_t compensate(input reading_t r);
		comp_t c;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, tmp, p, dv;
		ac1 = ext16(m_ac1); ac2 = ext16(m_ac2); ac3 = ext16(m_ac3);
		ac4 = {16'd0, m_ac4};
		ac5 = {16'd0, m_ac56[31:16]}; ac6 = {16'd0, m_ac56[15:0]};
		b1 = ext16(m_b12[31:16]); b2 = ext16(m_b12[15:0]);
		mc = ext16(m_mcmd[31:16]); md = ext16(m_mcmd[15:0]);
		if (r.kind) m_raw_p = 19'(r.raw >> (8 - m_oss));
		else m_raw_t = r.raw[15:0];
		c = '{temp: 32'd0, pres: 32'd0, div_err: 1'b1};
		x1 = sar(({16'd0, m_raw_t} - ac6) * ac5, 15);
		dv = x1 + md;
		if (dv == 0) return c;
		x2 = quot(mc << 11, dv);
		b5 = x1 + x2;
		c.temp = sar(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = sar(b6 * b6, 12);
		x1 = sar(b2 * sq, 11);
		x2 = sar(ac2 * b6, 11);
		x3 = x1 + x2;
		tmp = (ac1 * 32'd4 + x3) << m_oss;
		b3 = quot(tmp + 32'd2, 32'd4);
		x1 = sar(ac3 * b6, 13);
		x2 = sar(b1 * sq, 16);
		x3 = sar(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		b7 = ({13'd0, m_raw_p} - b3) * (32'd50000 >> m_oss);
		if (b4 == 0) begin
			c.temp = 32'd0;
			return c;
		end
		p = !b7[31] ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
		x1 = sar(p, 8) * sar(p, 8);
		x1 = sar(x1 * 32'd3038, 16);
		x2 = sar(-32'd7357 * p, 16);
		c.pres = p + sar(x1 + x2 + 32'd3791, 4);
		c.div_err = 1'b0;
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver: one transfer at a time from the pending queue
	int send_gap;
	reading_t cur;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_accepted) begin
				expected_comps.push_back(compensate(cur));
				void'(pending_readings.pop_front());
				send_gap = pick_gap();
			end
			if (s_tvalid && !in_accepted) begin
				// hold until taken
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_readings.size() > 0 && !hold_sender) begin
				cur = pending_readings[0];
				s_tvalid <= 1'b1;
				s_tdata <= cur.raw;
				s_tuser <= cur.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
			in_accepted = 1'b0;
			// receiver backpressure
			if (wait_gap > 0) begin
				wait_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				wait_gap = pick_gap();
			end
		end
	end

	// monitor: compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (s_tvalid && s_tready) in_accepted = 1'b1;
			if (m_tvalid && m_tready) begin
				comp_t e;
				if (expected_comps.size() == 0) begin
					$error("unexpected output transfer %h", m_tdata);
					fail_count++;
				end else begin
					e = expected_comps.pop_front();
					if (m_tdata[31:0] !== e.temp) begin
						$error("temperature_tenths exp %0d got %0d",
							$signed(e.temp), $signed(m_tdata[31:0]));
						fail_count++;
					end
					if (m_tdata[63:32] !== e.pres) begin
						$error("pressure_pa exp %0d got %0d",
							$signed(e.pres), $signed(m_tdata[63:32]));
						fail_count++;
					end
					if (m_tuser !== e.div_err) begin
						$error("divide_error exp %0b got %0b", e.div_err, m_tuser);
						fail_count++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_AC1:     m_ac1 = val[15:0];
			REG_AC2:     m_ac2 = val[15:0];
			REG_AC3:     m_ac3 = val[15:0];
			REG_AC4:     m_ac4 = val[15:0];
			REG_AC5_AC6: m_ac56 = val;
			REG_B1_B2:   m_b12 = val;
			REG_MC_MD:   m_mcmd = val;
			default:     m_oss = val[1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_readings.size() == 0 && !s_tvalid && expected_comps.size() == 0);
		repeat (600) @(posedge clk);
	endtask

	task automatic push(input logic kind, input logic [23:0] raw);
		pending_readings.push_back('{kind: kind, raw: raw});
	endtask

	// typical datasheet calibration
	task automatic load_typical(input logic [1:0] oss);
		write_reg(REG_AC1, 32'(16'sd408));
		write_reg(REG_AC2, 32'(-16'sd72) & 32'hFFFF);
		write_reg(REG_AC3, 32'(-16'sd14383) & 32'hFFFF);
		write_reg(REG_AC4, 32'd32741);
		write_reg(REG_AC5_AC6, {16'd32757, 16'd23153});
		write_reg(REG_B1_B2, {16'd6190, 16'd4});
		write_reg(REG_MC_MD, {-16'sd8711, 16'd2868});
		write_reg(REG_OSS, {30'd0, oss});
	endtask

	task automatic random_coefs();
		for (int i = 0; i < 8; i++) write_reg(3'(i), $urandom());
	endtask

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		wait_gap = 0;
		send_gap = 0;
		hold_sender = 1'b0;
		in_accepted = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		{m_ac1, m_ac2, m_ac3, m_ac4} = '0;
		{m_ac56, m_b12, m_mcmd} = '0;
		m_oss = '0; m_raw_t = '0; m_raw_p = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-zero coefficients: zero divisor before any reading
		push(1'b0, 24'd0);
		push(1'b1, 24'hFFFFFF);
		drain();

		// datasheet example, then field extremes
		load_typical(2'd0);
		push(1'b0, 24'd27898);
		push(1'b1, 24'd23843 << 8);
		push(1'b0, 24'hFFFFFF);
		push(1'b0, 24'h000000);
		push(1'b1, 24'h000000);
		push(1'b1, 24'hFFFFFF);
		push(1'b0, 24'hFF0000);
		drain();
		for (int o = 1; o < 4; o++) begin
			write_reg(REG_OSS, o);
			push(1'b1, 24'hFFFFFF);
			push(1'b1, 24'h5A5A5A);
			push(1'b0, 24'd27898);
			drain();
		end

		// extreme coefficients and a forced zero B4
		for (int i = 0; i < 7; i++) write_reg(3'(i), 32'hFFFFFFFF);
		push(1'b0, 24'h123456);
		push(1'b1, 24'h654321);
		drain();
		for (int i = 0; i < 7; i++) write_reg(3'(i), 32'h80008000);
		push(1'b0, 24'h008000);
		drain();
		load_typical(2'd3);
		write_reg(REG_AC4, 32'd0);
		push(1'b0, 24'd27898);
		push(1'b1, 24'hABCDEF);
		drain();

		// random phases: mostly realistic coefficients, some fully random
		for (int ph = 0; ph < 17; ph++) begin
			if (ph % 3 == 2) random_coefs();
			else load_typical(2'($urandom_range(0, 3)));
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(0, 3) == 0) push(1'b0, 24'($urandom()));
				else if ($urandom_range(0, 1) == 0)
					push(1'b0, 24'($urandom_range(20000, 36000)));
				else push(1'b1, 24'($urandom()));
			end
			// sender pause mid-stream until every result is back
			if (ph == 5) begin
				wait (pending_readings.size() <= 50);
				hold_sender = 1'b1;
				wait (expected_comps.size() == 0 && !s_tvalid);
				hold_sender = 1'b0;
			end
			drain();
		end

		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/bsc_pkg.sv
rtl/core/bsc_muldiv.sv
rtl/core/bsc_seq.sv
rtl/core/barometric_sensor_compensation.sv
test/tb_barometric_sensor_compensation.sv
